// ===== hdl/brts_pkg.sv =====
// package: types, codes and reset constants for the broadcast reply turn scheduler
`timescale 1ns / 1ps

package brts_pkg;

   localparam int unsigned ID_W      = 8;
   localparam int unsigned SLOT_W    = 16;
   localparam int unsigned TIMEOUT_W = 20;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 20;

   localparam logic [ID_W-1:0]      RESET_OWN_ID       = 8'd1;
   localparam logic [SLOT_W-1:0]    RESET_PING_SLOT    = 16'd3000;
   localparam logic [TIMEOUT_W-1:0] RESET_READ_TIMEOUT = 20'd50000;
   localparam logic [ID_W-1:0]      NO_ID              = 8'hFF;
   localparam logic [ID_W-1:0]      FIRST_ID           = 8'd1;

   typedef enum logic [1:0] {
      OP_PING   = 2'd0,
      OP_LIST   = 2'd1,
      OP_STATUS = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_PING    = 2'd1,
      MODE_COLLECT = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic {
      ACT_REPLY   = 1'b0,
      ACT_TIMEOUT = 1'b1
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PING_SLOT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_TIMEOUT = 2'd2;

   typedef struct packed {
      op_type            opcode;
      logic [ID_W-1:0]   bus_id;
      logic              list_last;
      logic [TIME_W-1:0] now_us;
   } item_type;

   typedef struct packed {
      logic       valid;
      action_type action;
   } result_type;

endpackage

// ===== hdl/brts_in_reg.sv =====
// input register stage: holds one request beat until the core takes it
`timescale 1ns / 1ps

module brts_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  brts_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output brts_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   brts_pkg::item_type item_ff;
   logic               load;

   // taken whenever the stage is empty or drains this cycle
   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/brts_core.sv =====
// scheduler core: configuration registers, turn state and per-beat decision logic
`timescale 1ns / 1ps

module brts_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [brts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [brts_pkg::CSR_DAT_W-1:0]       csr_wdata,
   input  logic                                 advance,
   input  brts_pkg::item_type                   item,
   output brts_pkg::result_type                 result
);

   logic [brts_pkg::ID_W-1:0]      own_id_ff;
   logic [brts_pkg::SLOT_W-1:0]    ping_slot_ff;
   logic [brts_pkg::TIMEOUT_W-1:0] read_timeout_ff;

   brts_pkg::mode_type             mode_ff, mode_in;
   logic [brts_pkg::ID_W-1:0]      expected_ff, expected_in;
   logic [brts_pkg::ID_W-1:0]      pred_ff, pred_in;
   logic                           found_ff, found_in;
   logic [brts_pkg::TIME_W-1:0]    mark_ff, mark_in;

   logic [brts_pkg::TIME_W-1:0]    elapsed;
   logic                           slot_done;
   logic                           read_expired;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff       <= brts_pkg::RESET_OWN_ID;
         ping_slot_ff    <= brts_pkg::RESET_PING_SLOT;
         read_timeout_ff <= brts_pkg::RESET_READ_TIMEOUT;
      end else if (csr_write) begin
         unique case (csr_index)
            brts_pkg::CSR_OWN_ID:       own_id_ff       <= csr_wdata[brts_pkg::ID_W-1:0];
            brts_pkg::CSR_PING_SLOT:    ping_slot_ff    <= csr_wdata[brts_pkg::SLOT_W-1:0];
            brts_pkg::CSR_READ_TIMEOUT: read_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // time differences wrap modulo 2^32
   assign elapsed      = item.now_us - mark_ff;
   assign slot_done    = elapsed >= {{(brts_pkg::TIME_W-brts_pkg::SLOT_W){1'b0}}, ping_slot_ff};
   assign read_expired = elapsed >=
                         {{(brts_pkg::TIME_W-brts_pkg::TIMEOUT_W){1'b0}}, read_timeout_ff};

   always_comb begin
      mode_in       = mode_ff;
      expected_in   = expected_ff;
      pred_in       = pred_ff;
      found_in      = found_ff;
      mark_in       = mark_ff;
      result.valid  = 1'b0;
      result.action = brts_pkg::ACT_REPLY;
      if (advance) begin
         unique case (mode_ff)
            brts_pkg::MODE_PING: begin
               if (item.opcode == brts_pkg::OP_STATUS) begin
                  // jump past the reply just heard
                  expected_in = item.bus_id + 8'd1;
               end else if (item.opcode == brts_pkg::OP_TICK && slot_done) begin
                  mark_in     = item.now_us;
                  expected_in = expected_ff + 8'd1;
               end
               if (expected_in == own_id_ff) begin
                  mode_in      = brts_pkg::MODE_IDLE;
                  result.valid = 1'b1;
               end
            end
            brts_pkg::MODE_READ: begin
               if (item.opcode == brts_pkg::OP_STATUS) begin
                  mark_in = item.now_us;
                  if (item.bus_id == pred_ff) begin
                     mode_in      = brts_pkg::MODE_IDLE;
                     result.valid = 1'b1;
                  end
               end else if (item.opcode == brts_pkg::OP_TICK && read_expired) begin
                  mode_in       = brts_pkg::MODE_IDLE;
                  result.valid  = 1'b1;
                  result.action = brts_pkg::ACT_TIMEOUT;
               end
            end
            brts_pkg::MODE_IDLE, brts_pkg::MODE_COLLECT: begin
               if (item.opcode == brts_pkg::OP_PING) begin
                  expected_in = brts_pkg::FIRST_ID;
                  mark_in     = item.now_us;
                  if (own_id_ff == brts_pkg::FIRST_ID) begin
                     mode_in      = brts_pkg::MODE_IDLE;
                     result.valid = 1'b1;
                  end else begin
                     mode_in = brts_pkg::MODE_PING;
                  end
               end else if (item.opcode == brts_pkg::OP_LIST) begin
                  // first entry in idle opens a new list
                  if (mode_ff == brts_pkg::MODE_IDLE) begin
                     pred_in  = brts_pkg::NO_ID;
                     found_in = 1'b0;
                  end
                  mode_in = brts_pkg::MODE_COLLECT;
                  // entries after our own id leave the predecessor unchanged
                  if (!found_in) begin
                     if (item.bus_id == own_id_ff) begin
                        found_in = 1'b1;
                     end else begin
                        pred_in = item.bus_id;
                     end
                  end
                  if (item.list_last) begin
                     mode_in = brts_pkg::MODE_IDLE;
                     if (found_in) begin
                        if (pred_in == brts_pkg::NO_ID) begin
                           result.valid = 1'b1;
                        end else begin
                           mark_in = item.now_us;
                           mode_in = brts_pkg::MODE_READ;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= brts_pkg::MODE_IDLE;
         expected_ff <= brts_pkg::NO_ID;
         pred_ff     <= brts_pkg::NO_ID;
         found_ff    <= 1'b0;
         mark_ff     <= '0;
      end else begin
         mode_ff     <= mode_in;
         expected_ff <= expected_in;
         pred_ff     <= pred_in;
         found_ff    <= found_in;
         mark_ff     <= mark_in;
      end
   end

endmodule

// ===== hdl/brts_out_reg.sv =====
// result register: holds one response beat until the consumer takes it
`timescale 1ns / 1ps

module brts_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  brts_pkg::result_type result,
   output logic                 rsp_open,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_action
);

   logic                 valid_ff;
   logic                 valid_in;
   brts_pkg::action_type action_ff;

   // free when empty or being drained this cycle
   assign rsp_open = !valid_ff || rsp_ready;
   assign valid_in = rsp_open ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_open && result.valid) begin
         action_ff <= result.action;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_action = action_ff;

endmodule

// ===== hdl/broadcast_reply_turn_scheduler.sv =====
// a request beat is held in the input stage register; any response beat it causes is
// registered in the result register. throughput: one request beat per cycle; the input
// stage drains whenever the result register is empty or its beat is taken in the same cycle
// configuration writes are taken every cycle (csr_ready is always high)
// reset is synchronous, active high: mode idle, expected and predecessor ids 0xFF,
// own id 1, ping slot 3000 us, read timeout 50000 us
`timescale 1ns / 1ps

module broadcast_reply_turn_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_opcode,
   input  logic [brts_pkg::ID_W-1:0]      req_bus_id,
   input  logic                           req_list_last,
   input  logic [brts_pkg::TIME_W-1:0]    req_now_us,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_action,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [brts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [brts_pkg::CSR_DAT_W-1:0] csr_wdata
);

   brts_pkg::item_type   req_item;
   brts_pkg::item_type   item;
   brts_pkg::result_type result;
   logic                 item_valid;
   logic                 rsp_open;
   logic                 advance;

   assign req_item.opcode    = brts_pkg::op_type'(req_opcode);
   assign req_item.bus_id    = req_bus_id;
   assign req_item.list_last = req_list_last;
   assign req_item.now_us    = req_now_us;

   assign csr_ready = 1'b1;
   assign advance   = item_valid && rsp_open;

   brts_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   brts_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   brts_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .rsp_open   (rsp_open),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_action (rsp_action)
   );

   // a new response beat only comes from an item the core just processed
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("response beat without a processed item");

   // empty result register means the input stage can always take a beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a held item in the input stage keeps its contents
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid && !advance |=> item_valid && $stable(item))
      else $error("stalled item lost or changed");

endmodule

// ===== tb/broadcast_reply_turn_scheduler_test.sv =====
// testbench: directed and random bus events against a cycle-free predictor of reply turns
`timescale 1ns / 1ps

module broadcast_reply_turn_scheduler_test;
   import brts_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_opcode = 2'd0;
   logic [ID_W-1:0]      req_bus_id = '0;
   logic                 req_list_last = 1'b0;
   logic [TIME_W-1:0]    req_now_us = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_action;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   broadcast_reply_turn_scheduler dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_bus_id(req_bus_id),
      .req_list_last(req_list_last),
      .req_now_us(req_now_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // register shadows
   logic [ID_W-1:0]      cfg_own_id;
   logic [SLOT_W-1:0]    cfg_slot_us;
   logic [TIMEOUT_W-1:0] cfg_timeout_us;

   // turn state
   mode_type          turn_mode;
   logic [ID_W-1:0]   count_id;
   logic [ID_W-1:0]   pred_id;
   logic              own_seen;
   logic [TIME_W-1:0] mark_us;

   item_type   event_queue[$];
   action_type due_actions[$];

   int items_queued = 0;
   int items_taken  = 0;
   int failures     = 0;
   int replies_seen = 0;
   int timeouts_seen = 0;
   int settings_used = 0;
   int cycle_count  = 0;
   int hold_asked   = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int stall_style  = 0;
   int stall_left   = 40;
   int stall_tick   = 0;
   int burst_left   = 0;
   int gap_left     = 0;
   logic [TIME_W-1:0] bus_time;

   function automatic void log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   // one bus event applied to the turn state; pushes the action it causes, if any
   function automatic void advance_turn(input item_type it);
      logic [TIME_W-1:0] since_mark;
      since_mark = it.now_us - mark_us;
      case (turn_mode)
         MODE_PING: begin
            if (it.opcode == OP_STATUS) begin
               count_id = it.bus_id + 8'd1;
            end else if (it.opcode == OP_TICK && since_mark >= cfg_slot_us) begin
               mark_us  = it.now_us;
               count_id = count_id + 8'd1;
            end
            if (count_id == cfg_own_id) begin
               turn_mode = MODE_IDLE;
               due_actions.push_back(ACT_REPLY);
            end
         end
         MODE_READ: begin
            if (it.opcode == OP_STATUS) begin
               mark_us = it.now_us;
               if (it.bus_id == pred_id) begin
                  turn_mode = MODE_IDLE;
                  due_actions.push_back(ACT_REPLY);
               end
            end else if (it.opcode == OP_TICK && since_mark >= cfg_timeout_us) begin
               turn_mode = MODE_IDLE;
               due_actions.push_back(ACT_TIMEOUT);
            end
         end
         default: begin
            if (it.opcode == OP_PING) begin
               count_id  = FIRST_ID;
               mark_us   = it.now_us;
               turn_mode = MODE_PING;
               if (cfg_own_id == FIRST_ID) begin
                  turn_mode = MODE_IDLE;
                  due_actions.push_back(ACT_REPLY);
               end
            end else if (it.opcode == OP_LIST) begin
               if (turn_mode == MODE_IDLE) begin
                  pred_id   = NO_ID;
                  own_seen  = 1'b0;
                  turn_mode = MODE_COLLECT;
               end
               // entries after our own id leave the predecessor alone
               if (!own_seen) begin
                  if (it.bus_id == cfg_own_id) own_seen = 1'b1;
                  else pred_id = it.bus_id;
               end
               if (it.list_last) begin
                  turn_mode = MODE_IDLE;
                  if (own_seen) begin
                     if (pred_id == NO_ID) begin
                        due_actions.push_back(ACT_REPLY);
                     end else begin
                        mark_us   = it.now_us;
                        turn_mode = MODE_READ;
                     end
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void queue_item(input op_type op, input logic [ID_W-1:0] id,
                                      input logic last, input logic [TIME_W-1:0] now);
      item_type it;
      it.opcode    = op;
      it.bus_id    = id;
      it.list_last = last;
      it.now_us    = now;
      event_queue.push_back(it);
      items_queued++;
   endfunction

   function automatic logic [ID_W-1:0] foreign_id();
      logic [ID_W-1:0] id;
      do id = ($urandom_range(0, 9) == 0) ? NO_ID : 8'($urandom_range(0, 253));
      while (id == cfg_own_id);
      return id;
   endfunction

   // ping followed by ticks and replies of other nodes, usually closed by our predecessor
   function automatic void ping_round();
      int steps;
      bus_time = bus_time + $urandom_range(1, 50);
      queue_item(OP_PING, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), bus_time);
      steps = $urandom_range(0, 6);
      repeat (steps) begin
         if ($urandom_range(0, 1) == 1) begin
            bus_time = bus_time + $urandom_range(0, 2 * int'(cfg_slot_us) + 1);
            queue_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, bus_time);
         end else begin
            bus_time = bus_time + $urandom_range(0, 20);
            if ($urandom_range(0, 3) == 0)
               queue_item(OP_STATUS, 8'($urandom_range(0, 255)), 1'b0, bus_time);
            else
               queue_item(OP_STATUS, cfg_own_id - 8'($urandom_range(2, 20)), 1'b0, bus_time);
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         bus_time = bus_time + $urandom_range(0, 20);
         queue_item(OP_STATUS, cfg_own_id - 8'd1, 1'($urandom_range(0, 1)), bus_time);
      end
   endfunction

   // group read id list, then the wait for the predecessor or the timeout
   function automatic void read_round();
      int len, own_at, steps, span;
      logic [ID_W-1:0]   id, before_own;
      logic              closed, last;
      logic [TIME_W-1:0] wait_mark;
      len    = $urandom_range(1, 8);
      own_at = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, len - 1);
      before_own = NO_ID;
      closed = 1'b0;
      span   = (cfg_timeout_us > 0) ? int'(cfg_timeout_us) - 1 : 0;
      for (int i = 0; i < len; i++) begin
         if (i == own_at) id = cfg_own_id;
         else if (own_at >= 0 && i > own_at && $urandom_range(0, 5) == 0) id = cfg_own_id;
         else id = foreign_id();
         if (i < own_at) before_own = id;
         last = (i == len - 1) && ($urandom_range(0, 19) != 0);
         if (last) closed = 1'b1;
         bus_time = bus_time + $urandom_range(1, 20);
         queue_item(OP_LIST, id, last, bus_time);
      end
      if (!closed || own_at < 0 || before_own == NO_ID) return;
      wait_mark = bus_time;
      steps = $urandom_range(0, 4);
      repeat (steps) begin
         bus_time = wait_mark + $urandom_range(0, span);
         if ($urandom_range(0, 1) == 1) begin
            do id = foreign_id(); while (id == before_own);
            wait_mark = bus_time;
            queue_item(OP_STATUS, id, 1'($urandom_range(0, 1)), bus_time);
         end else begin
            queue_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), bus_time);
         end
      end
      steps = $urandom_range(0, 9);
      if (steps >= 1 && steps <= 5) begin
         bus_time = wait_mark + $urandom_range(0, span);
         queue_item(OP_STATUS, before_own, 1'b0, bus_time);
      end else if (steps > 5) begin
         bus_time = wait_mark + cfg_timeout_us + $urandom_range(0, 3);
         queue_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, bus_time);
      end
   endfunction

   function automatic void fill_random(input int target);
      int pick;
      while (items_queued < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) ping_round();
         else if (pick < 9) read_round();
         else queue_item(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), $urandom());
      end
   endfunction

   // called at a rising edge; leaves csr_valid high for the caller to lower
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_OWN_ID:       cfg_own_id     = val[ID_W-1:0];
         CSR_PING_SLOT:    cfg_slot_us    = val[SLOT_W-1:0];
         CSR_READ_TIMEOUT: cfg_timeout_us = val[TIMEOUT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [ID_W-1:0] own, input logic [SLOT_W-1:0] slot,
                           input logic [TIMEOUT_W-1:0] tmo);
      logic [11:0] junk_hi;
      logic [3:0]  junk_lo;
      junk_hi = $urandom_range(0, 4095);
      junk_lo = $urandom_range(0, 15);
      @(posedge clock);
      // bits above each register's width must be dropped
      write_csr(CSR_SPARE, CSR_DAT_W'($urandom()));
      write_csr(CSR_OWN_ID, {junk_hi, own});
      write_csr(CSR_PING_SLOT, {junk_lo, slot});
      write_csr(CSR_READ_TIMEOUT, tmo);
      csr_valid <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (items_taken != items_queued || due_actions.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sender: bursts of beats with random gaps
   always @(posedge clock) begin : sender
      item_type taken, beat;
      logic     offer;
      if (!reset) begin
         if (req_valid && req_ready) begin
            taken.opcode    = op_type'(req_opcode);
            taken.bus_id    = req_bus_id;
            taken.list_last = req_list_last;
            taken.now_us    = req_now_us;
            advance_turn(taken);
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (event_queue.size() > 0) begin
               beat = event_queue.pop_front();
               offer = 1'b1;
               req_opcode    <= beat.opcode;
               req_bus_id    <= beat.bus_id;
               req_list_last <= beat.list_last;
               req_now_us    <= beat.now_us;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
            req_valid <= offer;
         end
      end
   end

   // receiver: stall styles that change now and then, plus requested long hold-offs
   always @(posedge clock) begin : receiver
      logic take;
      if (hold_left > 0) begin
         hold_left--;
         take = 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         take = 1'b0;
      end else begin
         case (stall_style)
            0: take = 1'b1;
            1: take = ($urandom_range(0, 3) != 0);
            2: take = (stall_tick % 5) < 2;
            default: take = 1'($urandom_range(0, 1));
         endcase
         stall_tick++;
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(10, 120);
         end else begin
            stall_left--;
         end
      end
      rsp_ready <= take;
   end

   always @(posedge clock) begin : response_check
      action_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (due_actions.size() == 0) begin
            log_failure($sformatf("unexpected response beat: action %b", rsp_action));
         end else begin
            want = due_actions.pop_front();
            if (rsp_action !== want)
               log_failure($sformatf("action mismatch: expected %b, got %b", want, rsp_action));
            if (want == ACT_REPLY) replies_seen++;
            else timeouts_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d beats taken, %0d actions due",
                  cycle_count, items_taken, items_queued, due_actions.size());
         $display("FAIL broadcast_reply_turn_scheduler");
         $finish;
      end
   end

   initial begin : run_test
      cfg_own_id     = RESET_OWN_ID;
      cfg_slot_us    = RESET_PING_SLOT;
      cfg_timeout_us = RESET_READ_TIMEOUT;
      turn_mode = MODE_IDLE;
      count_id  = NO_ID;
      pred_id   = NO_ID;
      own_seen  = 1'b0;
      mark_us   = '0;

      // reset settings: own id 1
      queue_item(OP_STATUS, 8'd9, 1'b0, 32'd500);
      queue_item(OP_PING, 8'd0, 1'b0, 32'd1000);
      queue_item(OP_LIST, 8'd1, 1'b1, 32'd1500);
      queue_item(OP_LIST, 8'd0, 1'b0, 32'd1900);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'd1950);
      queue_item(OP_LIST, 8'd1, 1'b1, 32'd2000);
      queue_item(OP_STATUS, 8'd9, 1'b0, 32'd40000);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'd89999);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'd90000);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      settle();

      // largest settings
      set_regs(8'd252, 16'hFFFF, 20'hFFFFF);
      queue_item(OP_LIST, NO_ID, 1'b0, 32'd10);
      queue_item(OP_LIST, 8'd252, 1'b1, 32'd20);
      queue_item(OP_LIST, 8'd10, 1'b0, 32'd30);
      queue_item(OP_LIST, 8'd252, 1'b0, 32'd40);
      queue_item(OP_LIST, 8'd20, 1'b1, 32'd50);
      queue_item(OP_STATUS, 8'd20, 1'b0, 32'd60);
      queue_item(OP_STATUS, 8'd10, 1'b0, 32'd70);
      queue_item(OP_LIST, 8'd5, 1'b0, 32'd80);
      queue_item(OP_LIST, 8'd6, 1'b1, 32'd90);
      // slot expiry across the wrap of the microsecond clock
      queue_item(OP_PING, 8'd0, 1'b0, 32'hFFFF_FFF0);
      queue_item(OP_STATUS, 8'd250, 1'b0, 32'hFFFF_FFF8);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'hFFFF_FFF0 + 32'd65535);
      settle();

      // zero slot and timeout, own id 0
      set_regs(8'd0, 16'd0, 20'd0);
      queue_item(OP_PING, 8'd0, 1'b0, 32'd100);
      queue_item(OP_PING, 8'd0, 1'b0, 32'd200);
      queue_item(OP_LIST, 8'd0, 1'b1, 32'd210);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'd100);
      queue_item(OP_STATUS, NO_ID, 1'b0, 32'd300);
      queue_item(OP_LIST, 8'd3, 1'b0, 32'd400);
      queue_item(OP_PING, 8'd0, 1'b0, 32'd410);
      queue_item(OP_STATUS, 8'd254, 1'b0, 32'd420);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'd420);
      queue_item(OP_LIST, 8'd3, 1'b0, 32'd500);
      queue_item(OP_LIST, 8'd0, 1'b1, 32'd510);
      queue_item(OP_TICK, 8'd0, 1'b0, 32'd510);
      settle();

      // every ping answers at once; the receiver holds off so the block backs up
      set_regs(FIRST_ID, 16'd100, 20'd100);
      hold_asked++;
      bus_time = $urandom();
      repeat (80) begin
         bus_time = bus_time + $urandom_range(1, 9);
         queue_item(OP_PING, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), bus_time);
      end
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_regs(8'($urandom_range(2, 30)), 16'($urandom_range(1, 20)),
                        20'($urandom_range(1, 60)));
            1: set_regs(FIRST_ID, 16'($urandom_range(1, 10)), 20'($urandom_range(1, 30)));
            2: set_regs(8'd0, 16'd3, 20'd5);
            3: set_regs(8'd252, 16'hFFFF, 20'hFFFFF);
            4: set_regs(8'($urandom_range(0, 252)), 16'($urandom_range(1, 65535)),
                        20'($urandom_range(1, 1048575)));
            default: set_regs(8'($urandom_range(2, 252)), 16'($urandom_range(1, 100)),
                              20'($urandom_range(1, 500)));
         endcase
         bus_time = $urandom();
         fill_random(items_queued + 300);
         settle();
      end

      $display("%0d request beats over %0d register settings; %0d replies and %0d timeouts checked",
               items_taken, settings_used + 1, replies_seen, timeouts_seen);
      if (failures == 0) begin
         $display("PASS broadcast_reply_turn_scheduler");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAIL broadcast_reply_turn_scheduler");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/brts_pkg.sv
hdl/brts_in_reg.sv
hdl/brts_core.sv
hdl/brts_out_reg.sv
hdl/broadcast_reply_turn_scheduler.sv
tb/broadcast_reply_turn_scheduler_test.sv
